>>> design/dirty_rect_coalescer_core_assert.svh
// Assertion macros for the dirty rectangle coalescer.
// Included by the modules that carry concurrent checks; uses clk_i and rst_ni.
`ifndef DIRTY_RECT_COALESCER_CORE_ASSERT_SVH
`define DIRTY_RECT_COALESCER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define DRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Expression must never be true outside reset.
`define DRC_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`else

`define DRC_ASSERT(label, prop, msg)
`define DRC_ASSERT_NEVER(label, expr, msg)

`endif

`endif

>>> design/drc_pkg.sv
// Package for the dirty rectangle coalescer: sizes, codes, rectangle type
// and the overlap / bounding box helpers. No dependencies.
`timescale 1ns / 1ps

package drc_pkg;

  localparam int MAX_RECTS  = 32;
  localparam int COORD_BITS = 12;
  localparam int CNT_W      = $clog2(MAX_RECTS + 1);
  localparam int CFG_W      = 13;
  localparam int IN_W       = 16;
  localparam int IN_DATA_W  = 4 * IN_W;
  localparam int OUT_W      = ((4 * COORD_BITS + 7) / 8) * 8;
  // signed working width for clamping, holds 2^COORD_BITS and any input
  localparam int CLAMP_W    = 18;

  localparam logic [CFG_W-1:0]   WIDTH_RESET  = CFG_W'(480);
  localparam logic [CFG_W-1:0]   HEIGHT_RESET = CFG_W'(320);
  localparam logic [CLAMP_W-1:0] RES_LIMIT    = CLAMP_W'(1 << COORD_BITS);

  typedef enum logic {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_DRAIN = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIX,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] y2;
    logic [COORD_BITS-1:0] x2;
    logic [COORD_BITS-1:0] y1;
    logic [COORD_BITS-1:0] x1;
  } rect_t;

  // Inclusive bounds: overlap when at least one pixel is shared
  function automatic logic overlaps(rect_t a, rect_t b);
    return (a.x1 <= b.x2) && (b.x1 <= a.x2) && (a.y1 <= b.y2) && (b.y1 <= a.y2);
  endfunction

  function automatic rect_t unite(rect_t a, rect_t b);
    rect_t r;
    r.x1 = (a.x1 < b.x1) ? a.x1 : b.x1;
    r.y1 = (a.y1 < b.y1) ? a.y1 : b.y1;
    r.x2 = (a.x2 > b.x2) ? a.x2 : b.x2;
    r.y2 = (a.y2 > b.y2) ? a.y2 : b.y2;
    return r;
  endfunction

endpackage

>>> design/drc_clamp.sv
// Clamps an incoming rectangle to the screen and flags it when empty.
// Depends on drc_pkg.
`timescale 1ns / 1ps

module drc_clamp import drc_pkg::*; (
  input  logic signed [IN_W-1:0]  left_i,
  input  logic signed [IN_W-1:0]  top_i,
  input  logic signed [IN_W-1:0]  right_i,
  input  logic signed [IN_W-1:0]  bottom_i,
  input  logic        [CFG_W-1:0] width_i,
  input  logic        [CFG_W-1:0] height_i,
  output rect_t                   rect_o,
  output logic                    empty_o
);

  logic signed [CLAMP_W-1:0] l, t, r, b;
  logic        [CLAMP_W-1:0] w_ext, h_ext, w_lim, h_lim;
  logic signed [CLAMP_W-1:0] w_max, h_max;
  logic signed [CLAMP_W-1:0] x1, y1, x2, y2;

  // sign extend the inputs
  assign l = {{(CLAMP_W-IN_W){left_i[IN_W-1]}},   left_i};
  assign t = {{(CLAMP_W-IN_W){top_i[IN_W-1]}},    top_i};
  assign r = {{(CLAMP_W-IN_W){right_i[IN_W-1]}},  right_i};
  assign b = {{(CLAMP_W-IN_W){bottom_i[IN_W-1]}}, bottom_i};

  // resolution limited to the coordinate range; zero gives a max of -1
  assign w_ext = {{(CLAMP_W-CFG_W){1'b0}}, width_i};
  assign h_ext = {{(CLAMP_W-CFG_W){1'b0}}, height_i};
  assign w_lim = (w_ext > RES_LIMIT) ? RES_LIMIT : w_ext;
  assign h_lim = (h_ext > RES_LIMIT) ? RES_LIMIT : h_ext;
  assign w_max = $signed(w_lim) - $signed(CLAMP_W'(1));
  assign h_max = $signed(h_lim) - $signed(CLAMP_W'(1));

  // clamp
  assign x1 = l[CLAMP_W-1] ? '0 : l;
  assign y1 = t[CLAMP_W-1] ? '0 : t;
  assign x2 = (r < w_max) ? r : w_max;
  assign y2 = (b < h_max) ? b : h_max;

  assign empty_o   = (x2 < x1) || (y2 < y1);
  assign rect_o.x1 = x1[COORD_BITS-1:0];
  assign rect_o.y1 = y1[COORD_BITS-1:0];
  assign rect_o.x2 = x2[COORD_BITS-1:0];
  assign rect_o.y2 = y2[COORD_BITS-1:0];

endmodule

>>> design/drc_cell.sv
// One storage cell of the rectangle ring: holds a rectangle and takes its
// neighbor's value when enabled. Depends on drc_pkg.
`timescale 1ns / 1ps

module drc_cell import drc_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  rect_t rect_i,
  output rect_t rect_o
);

  rect_t rect_q, rect_d;

  assign rect_d = en_i ? rect_i : rect_q;

  always_ff @(posedge clk_i) begin
    rect_q <= rect_d;
  end

  assign rect_o = rect_q;

endmodule

>>> design/dirty_rect_coalescer_core.sv
// Dirty rectangle coalescer: a ring of MAX_RECTS cells rotates past one
// compare/merge head. An add word is accepted and clamped in idle, then the
// whole ring rotates once through the head, and a fixup state bumps the
// count after an append or loads the collapsed box when the add neither
// merged nor appended. An add that clamps to nothing stays in idle. A drain
// loads one word per stored rectangle into the output register, rotating the
// ring each time the output register is free (empty or m_axis_tready high).
// An empty drain loads its single word at the accept edge. A new word is
// taken only in idle, and only while the output register is empty or being
// emptied. The head is the only access point to the table. Depends on
// drc_pkg, drc_cell, drc_clamp and dirty_rect_coalescer_core_assert.svh.
`timescale 1ns / 1ps
`include "dirty_rect_coalescer_core_assert.svh"

module dirty_rect_coalescer_core import drc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,  // left, top, right, bottom
  input  logic                 s_axis_tuser,  // req_type
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata,  // out_left, out_top, out_right, out_bottom
  output logic                 m_axis_tlast,  // is_last
  output logic                 m_axis_tuser   // none_dirty
);

  state_e           state_q, state_d;
  logic [CFG_W-1:0] width_q, height_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             merged_q, merged_d;
  logic             appended_q, appended_d;
  rect_t            a_q, a_d;
  rect_t            acc_q, acc_d;
  logic             out_valid_q, out_valid_d;
  rect_t            out_rect_q, out_rect_d;
  logic             out_last_q, out_last_d;
  logic             out_none_q, out_none_d;

  rect_t                 cell_in  [MAX_RECTS];
  rect_t                 cell_out [MAX_RECTS];
  logic [MAX_RECTS-1:0]  cell_en;
  rect_t                 head, head_fb;
  rect_t                 clamp_rect;
  logic                  clamp_empty;

  logic in_acc, out_free, valid_head, hit, app, walk_end, drain_end;
  logic shift, fix_load, load_out;

  // clamp the incoming word
  drc_clamp u_clamp (
    .left_i   (s_axis_tdata[IN_W-1:0]),
    .top_i    (s_axis_tdata[2*IN_W-1:IN_W]),
    .right_i  (s_axis_tdata[3*IN_W-1:2*IN_W]),
    .bottom_i (s_axis_tdata[4*IN_W-1:3*IN_W]),
    .width_i  (width_q),
    .height_i (height_q),
    .rect_o   (clamp_rect),
    .empty_o  (clamp_empty)
  );

  // ring of cells: cell i takes cell i+1, the last takes the head feedback
  for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
    rect_t nxt;
    if (i == MAX_RECTS - 1) begin : g_tail
      assign nxt = head_fb;
    end else begin : g_mid
      assign nxt = cell_out[i+1];
    end
    if (i == 0) begin : g_head
      assign cell_in[i] = (state_q == ST_FIX) ? acc_q : nxt;
    end else begin : g_body
      assign cell_in[i] = nxt;
    end
    drc_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (cell_en[i]),
      .rect_i (cell_in[i]),
      .rect_o (cell_out[i])
    );
  end

  assign head    = cell_out[0];
  assign cell_en = {MAX_RECTS{shift}} | MAX_RECTS'(fix_load);

  // head compare: first overlap merges, the free slot after the entries appends
  assign out_free   = !out_valid_q || m_axis_tready;
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign valid_head = k_q < count_q;
  assign hit        = (state_q == ST_WALK) && valid_head && !merged_q && overlaps(head, a_q);
  assign app        = (state_q == ST_WALK) && (k_q == count_q) && !merged_q;
  assign head_fb    = hit ? unite(head, a_q) : (app ? a_q : head);
  assign walk_end   = k_q == CNT_W'(MAX_RECTS - 1);
  assign drain_end  = (k_q + CNT_W'(1)) == count_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (req_e'(s_axis_tuser) == REQ_DRAIN) begin
            if (count_q != '0) state_d = ST_DRAIN;
          end else if (!clamp_empty) begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK:  if (walk_end) state_d = ST_FIX;
      ST_FIX:   state_d = ST_IDLE;
      ST_DRAIN: if (out_free && drain_end) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    shift         = 1'b0;
    fix_load      = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = out_free;
        load_out      = in_acc && (req_e'(s_axis_tuser) == REQ_DRAIN) && (count_q == '0);
      end
      ST_WALK:  shift = 1'b1;
      ST_FIX:   fix_load = !merged_q && !appended_q;
      ST_DRAIN: begin
        shift    = out_free;
        load_out = out_free;
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    count_d     = count_q;
    k_d         = k_q;
    merged_d    = merged_q;
    appended_d  = appended_q;
    a_d         = a_q;
    acc_d       = acc_q;
    out_rect_d  = out_rect_q;
    out_last_d  = out_last_q;
    out_none_d  = out_none_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        k_d        = '0;
        merged_d   = 1'b0;
        appended_d = 1'b0;
        a_d        = clamp_rect;
        acc_d      = clamp_rect;
      end
      ST_WALK: begin
        k_d = k_q + CNT_W'(1);
        if (hit) merged_d = 1'b1;
        if (app) appended_d = 1'b1;
        if (valid_head) acc_d = unite(acc_q, head);
      end
      ST_FIX: begin
        if (fix_load) count_d = CNT_W'(1);
        else if (appended_q) count_d = count_q + CNT_W'(1);
      end
      ST_DRAIN: begin
        if (out_free) begin
          k_d = k_q + CNT_W'(1);
          if (drain_end) count_d = '0;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_valid_d = 1'b1;
      if (state_q == ST_DRAIN) begin
        out_rect_d = head;
        out_last_d = drain_end;
        out_none_d = 1'b0;
      end else begin
        out_rect_d = '0;
        out_last_d = 1'b1;
        out_none_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      merged_q    <= 1'b0;
      appended_q  <= 1'b0;
      out_valid_q <= 1'b0;
      width_q     <= WIDTH_RESET;
      height_q    <= HEIGHT_RESET;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      k_q         <= k_d;
      merged_q    <= merged_d;
      appended_q  <= appended_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i;
          CFG_SCREEN_HEIGHT: height_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    acc_q      <= acc_d;
    out_rect_q <= out_rect_d;
    out_last_q <= out_last_d;
    out_none_q <= out_none_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_rect_q.y2, out_rect_q.x2, out_rect_q.y1, out_rect_q.x1});
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_none_q;

  // checks
  `DRC_ASSERT_NEVER(a_count_range, count_q > CNT_W'(MAX_RECTS), "entry count above table size")
  `DRC_ASSERT_NEVER(a_merge_or_append, merged_q && appended_q, "add both merged and appended")
  `DRC_ASSERT(a_drain_done, (state_q == ST_DRAIN) && out_free && drain_end |=> (count_q == '0) && (state_q == ST_IDLE), "drain end did not clear the table")
  `DRC_ASSERT(a_count_change, !$stable(count_q) |-> ($past(state_q) == ST_FIX) || ($past(state_q) == ST_DRAIN), "entry count changed outside fixup or drain")
  `DRC_ASSERT(a_none_last, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast, "empty-table word without last flag")

endmodule
